@@ rtl/vcsa_pkg.sv @@
// ----------------------------------------------------------------------------
// vcsa_pkg
// Shared types and constants for the voice channel stealing allocator.
// ----------------------------------------------------------------------------
package vcsa_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DRIVE_SHIFT = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MASTER_VOL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAME_SOUND_MIN_PRIO = 2'd1;

  // allocation rules
  localparam logic [1:0] RULE_SAME_SOUND = 2'd0;
  localparam logic [1:0] RULE_LOWER_VOLUME = 2'd1;
  localparam logic [1:0] RULE_LOWER_PRIORITY = 2'd2;
  localparam logic [1:0] RULE_OLDEST = 2'd3;

  localparam logic [15:0] EMPTY_SOUND = 16'hFFFF;
  localparam logic signed [31:0] AGE_MAX = 32'sh7FFF_FFFF;

  localparam logic [3:0] MASTER_VOL_RESET = 4'd8;
  localparam logic [3:0] SAME_SOUND_MIN_PRIO_RESET = 4'd1;

  typedef struct packed {
    logic [15:0] sound_id;
    logic [7:0]  amplitude;
    logic [14:0] persistence;
    logic [3:0]  priority_req;
    logic        sound_loaded;
    logic [31:0] now_tick;
  } req_t;

  typedef struct packed {
    logic       granted;
    logic [2:0] channel;
    logic [7:0] drive_level;
    logic [1:0] rule_used;
  } res_t;

  typedef struct packed {
    logic [15:0]        sound;
    logic [7:0]         volume;
    logic [3:0]         prio;
    logic signed [31:0] age;
  } chan_entry_t;

  localparam chan_entry_t CHAN_RESET = '{
    sound:    EMPTY_SOUND,
    volume:   8'd0,
    prio:     4'd0,
    age:      32'sd0
  };

endpackage

@@ rtl/vcsa_chan_store.sv @@
// ----------------------------------------------------------------------------
// vcsa_chan_store
// Channel state memory: one write port, one registered read port. Per-entry
// valid bits make never-written entries read back as the empty channel.
// ----------------------------------------------------------------------------
module vcsa_chan_store #(
  parameter int unsigned NUM_CHANNELS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [$clog2(NUM_CHANNELS)-1:0]   rd_addr,
  output vcsa_pkg::chan_entry_t             rd_entry,
  input  logic                              wr_en,
  input  logic [$clog2(NUM_CHANNELS)-1:0]   wr_addr,
  input  vcsa_pkg::chan_entry_t             wr_entry
);

  vcsa_pkg::chan_entry_t mem [NUM_CHANNELS];
  vcsa_pkg::chan_entry_t rd_q;
  logic [NUM_CHANNELS-1:0] entry_valid;
  logic rd_valid_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (wr_en) begin
        entry_valid[wr_addr] <= 1'b1;
      end
      rd_valid_q <= entry_valid[rd_addr];
    end
  end

  assign rd_entry = rd_valid_q ? rd_q : vcsa_pkg::CHAN_RESET;

endmodule

@@ rtl/voice_channel_stealing_allocator.sv @@
// ----------------------------------------------------------------------------
// voice_channel_stealing_allocator
// Picks a playback channel for each play request, stealing one if needed.
// ----------------------------------------------------------------------------
// A request beat is taken only while the block is idle and no register write
// is offered; a register write offered in the same cycle goes first. A request
// that is muted (global volume or amplitude zero) is accepted and then loads
// its result register. Any other request is accepted while the first read is
// issued, then streams the channel memory through its single read port, one
// channel after another (aging each entry and writing it back), and then
// resolves the pick, claims the channel and loads the result register.
// The result register parts the two sides; a result not yet taken holds the
// block in its resolve step until the result register frees up. Channel state
// comes out of reset as empty channels; there is no clearing pass. The config
// port is ready only while the block is idle.
// ----------------------------------------------------------------------------
module voice_channel_stealing_allocator #(
  parameter int unsigned NUM_CHANNELS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  vcsa_pkg::req_t                      req,
  output logic                                res_valid,
  input  logic                                res_ready,
  output vcsa_pkg::res_t                      res,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vcsa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [3:0]                          cfg_data
);

  localparam int unsigned IDX_W = $clog2(NUM_CHANNELS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // configuration
  logic [3:0] master_vol;
  logic [3:0] same_sound_min_prio;

  // request context
  vcsa_pkg::req_t req_q;
  logic           ignored;
  logic [31:0]    elapsed;
  logic [31:0]    last_play_tick;
  logic           same_sound_en;

  // scan state
  logic [IDX_W-1:0] cnt;
  logic             ss_found;
  logic [IDX_W-1:0] ss_idx;
  logic             lv_found;
  logic [IDX_W-1:0] lv_idx;
  logic             lp_found;
  logic [IDX_W-1:0] lp_idx;
  logic             old_found;
  logic [IDX_W-1:0] old_idx;
  logic signed [31:0] best_age;

  // memory interface
  logic [IDX_W-1:0]      rd_addr;
  vcsa_pkg::chan_entry_t rd_entry;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  vcsa_pkg::chan_entry_t mem_wentry;

  logic req_fire;
  logic res_free;
  logic req_ignore;

  // register writes win over a request offered in the same cycle
  assign req_ready  = (state == ST_IDLE) && !cfg_valid;
  assign req_fire   = req_valid && req_ready;
  assign res_free   = !res_valid || res_ready;
  assign req_ignore = (master_vol == 4'd0) || (req.amplitude == 8'd0);
  assign cfg_ready  = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      master_vol          <= vcsa_pkg::MASTER_VOL_RESET;
      same_sound_min_prio <= vcsa_pkg::SAME_SOUND_MIN_PRIO_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        vcsa_pkg::CFG_MASTER_VOL:          master_vol <= cfg_data;
        vcsa_pkg::CFG_SAME_SOUND_MIN_PRIO: same_sound_min_prio <= cfg_data;
        default: ;
      endcase
    end
  end

  // --- aging of the entry on the read port ---------------------------------
  logic signed [33:0] age_sum;
  logic signed [31:0] aged;
  vcsa_pkg::chan_entry_t aged_entry;

  always_comb begin
    age_sum = {{2{rd_entry.age[31]}}, rd_entry.age} + $signed({2'b00, elapsed});
    // ages only move up, so overflow shows as a positive sum past the max
    if (!age_sum[33] && (|age_sum[32:31])) begin
      aged = vcsa_pkg::AGE_MAX;
    end else begin
      aged = age_sum[31:0];
    end
    aged_entry     = rd_entry;
    aged_entry.age = aged;
  end

  // match terms for the channel under scan
  logic hit_ss;
  logic hit_lv;
  logic hit_lp;
  logic hit_old;

  assign hit_ss  = same_sound_en && (rd_entry.sound == req_q.sound_id)
                   && (rd_entry.volume <= req_q.amplitude);
  assign hit_lv  = rd_entry.volume < req_q.amplitude;
  assign hit_lp  = rd_entry.prio < req_q.priority_req;
  assign hit_old = (aged > 32'sd0) && (aged > best_age);

  // --- resolve ---------------------------------------------------------------
  logic             pick_found;
  logic [IDX_W-1:0] pick_idx;
  logic [1:0]       pick_rule;
  logic             claim;
  logic [11:0]      drive_prod;
  logic [11:0]      drive_wide;
  logic [7:0]       drive_sat;
  logic [IDX_W+2:0] pick_ext;
  vcsa_pkg::chan_entry_t claim_entry;

  always_comb begin
    pick_found = 1'b1;
    pick_idx   = old_idx;
    pick_rule  = vcsa_pkg::RULE_OLDEST;
    if (ss_found) begin
      pick_idx  = ss_idx;
      pick_rule = vcsa_pkg::RULE_SAME_SOUND;
    end else if (lv_found) begin
      pick_idx  = lv_idx;
      pick_rule = vcsa_pkg::RULE_LOWER_VOLUME;
    end else if (lp_found) begin
      pick_idx  = lp_idx;
      pick_rule = vcsa_pkg::RULE_LOWER_PRIORITY;
    end else if (!old_found) begin
      pick_found = 1'b0;
    end
    claim = !ignored && pick_found && req_q.sound_loaded;

    drive_prod = {4'd0, req_q.amplitude} * {8'd0, master_vol};
    drive_wide = drive_prod >> vcsa_pkg::DRIVE_SHIFT;
    drive_sat  = (|drive_wide[11:8]) ? 8'hFF : drive_wide[7:0];
    pick_ext   = {3'd0, pick_idx};

    claim_entry.sound  = req_q.sound_id;
    claim_entry.volume = req_q.amplitude;
    claim_entry.prio   = req_q.priority_req;
    claim_entry.age    = -$signed({17'd0, req_q.persistence});
  end

  // --- memory port steering ------------------------------------------------
  always_comb begin
    rd_addr    = '0;
    mem_we     = 1'b0;
    mem_waddr  = cnt;
    mem_wentry = aged_entry;
    unique case (state)
      ST_SCAN: begin
        rd_addr = (cnt == LAST_IDX) ? '0 : IDX_W'(cnt + 1'b1);
        mem_we  = 1'b1;
      end
      ST_FINISH: begin
        mem_we     = claim && res_free;
        mem_waddr  = pick_idx;
        mem_wentry = claim_entry;
      end
      default: ;
    endcase
  end

  vcsa_chan_store #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .wr_en    (mem_we),
    .wr_addr  (mem_waddr),
    .wr_entry (mem_wentry)
  );

  // --- sequencer -------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          state_next = req_ignore ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt == LAST_IDX) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (res_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      last_play_tick <= '0;
      res_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (req_fire && !req_ignore) begin
        last_play_tick <= req.now_tick;
      end
      if (state == ST_FINISH && res_free) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // request context and scan trackers
  always_ff @(posedge clk) begin
    if (req_fire) begin
      req_q         <= req;
      ignored       <= req_ignore;
      elapsed       <= req.now_tick - last_play_tick;
      same_sound_en <= req.priority_req > same_sound_min_prio;
      cnt           <= '0;
      ss_found      <= 1'b0;
      lv_found      <= 1'b0;
      lp_found      <= 1'b0;
      old_found     <= 1'b0;
      best_age      <= 32'sd0;
    end else if (state == ST_SCAN) begin
      cnt <= IDX_W'(cnt + 1'b1);
      if (!ss_found && hit_ss) begin
        ss_found <= 1'b1;
        ss_idx   <= cnt;
      end
      if (!lv_found && hit_lv) begin
        lv_found <= 1'b1;
        lv_idx   <= cnt;
      end
      if (!lp_found && hit_lp) begin
        lp_found <= 1'b1;
        lp_idx   <= cnt;
      end
      // strict compare keeps the lowest index among equal ages
      if (hit_old) begin
        old_found <= 1'b1;
        old_idx   <= cnt;
        best_age  <= aged;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && res_free) begin
      res.granted     <= claim;
      res.channel     <= claim ? pick_ext[2:0] : 3'd0;
      res.drive_level <= claim ? drive_sat : 8'd0;
      res.rule_used   <= claim ? pick_rule : 2'd0;
    end
  end

  // --- checks ----------------------------------------------------------------
  a_ungranted_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.granted |->
      res.channel == 3'd0 && res.drive_level == 8'd0 && res.rule_used == 2'd0)
    else $error("ungranted result carries nonzero fields");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while previous one in flight");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state != ST_IDLE)
    else $error("channel memory written while idle");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == ST_FINISH)
    else $error("result appeared without a resolve step");

endmodule

@@ dv/voice_channel_stealing_allocator_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voice_channel_stealing_allocator_check
// Watches the request, result and register channels and keeps its own copy of
// the channel table. Each request beat yields one predicted grant, and each
// result beat is compared field by field against the oldest predicted grant.
// ----------------------------------------------------------------------------
module voice_channel_stealing_allocator_check #(
  parameter int unsigned NUM_CHANNELS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  input  logic                           req_ready,
  input  vcsa_pkg::req_t                 req,
  input  logic                           res_valid,
  input  logic                           res_ready,
  input  vcsa_pkg::res_t                 res,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [vcsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [3:0]                     cfg_data,
  output int                             errors,
  output int                             waiting
);

  logic [15:0]        ch_sound [NUM_CHANNELS];
  logic [7:0]         ch_vol   [NUM_CHANNELS];
  logic [3:0]         ch_prio  [NUM_CHANNELS];
  logic signed [31:0] ch_age   [NUM_CHANNELS];
  logic [31:0]        last_tick;
  logic [3:0]         volume;
  logic [3:0]         min_prio;

  vcsa_pkg::res_t grant_q [$];
  int             err_n;

  // unless muted: age all channels, run the four passes, claim the winner if loaded
  task automatic allocate_channel(input vcsa_pkg::req_t r, output vcsa_pkg::res_t g);
    longint             aged;
    int                 pick;
    logic [1:0]         rule;
    logic signed [31:0] best;
    int                 drive;
    g    = '0;
    pick = -1;
    rule = vcsa_pkg::RULE_SAME_SOUND;
    if (volume == 4'd0 || r.amplitude == 8'd0) return;

    for (int i = 0; i < NUM_CHANNELS; i++) begin
      aged = longint'(ch_age[i]) + longint'({32'd0, r.now_tick - last_tick});
      if (aged > longint'(vcsa_pkg::AGE_MAX)) aged = longint'(vcsa_pkg::AGE_MAX);
      ch_age[i] = aged[31:0];
    end

    if (r.priority_req > min_prio) begin
      for (int i = 0; i < NUM_CHANNELS && pick < 0; i++) begin
        if (ch_sound[i] == r.sound_id && ch_vol[i] <= r.amplitude) begin
          pick = i;
          rule = vcsa_pkg::RULE_SAME_SOUND;
        end
      end
    end
    for (int i = 0; i < NUM_CHANNELS && pick < 0; i++) begin
      if (ch_vol[i] < r.amplitude) begin
        pick = i;
        rule = vcsa_pkg::RULE_LOWER_VOLUME;
      end
    end
    for (int i = 0; i < NUM_CHANNELS && pick < 0; i++) begin
      if (ch_prio[i] < r.priority_req) begin
        pick = i;
        rule = vcsa_pkg::RULE_LOWER_PRIORITY;
      end
    end
    if (pick < 0) begin
      best = 32'sd0;
      // strict compare keeps the lowest index on ties
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (ch_age[i] > best) begin
          best = ch_age[i];
          pick = i;
          rule = vcsa_pkg::RULE_OLDEST;
        end
      end
    end

    last_tick = r.now_tick;
    if (!r.sound_loaded || pick < 0) return;

    ch_sound[pick] = r.sound_id;
    ch_vol[pick]   = r.amplitude;
    ch_prio[pick]  = r.priority_req;
    ch_age[pick]   = -{17'd0, r.persistence};

    drive = (int'(r.amplitude) * int'(volume)) >> vcsa_pkg::DRIVE_SHIFT;
    if (drive > 255) drive = 255;

    g.granted     = 1'b1;
    g.channel     = pick[2:0];
    g.drive_level = drive[7:0];
    g.rule_used   = rule;
  endtask

  task automatic flag_beat(input string what, input vcsa_pkg::res_t want,
                           input vcsa_pkg::res_t got);
    err_n++;
    if (err_n <= 10) begin
      $display("%0t: %s: want g=%0d ch=%0d drv=%0d rule=%0d, got g=%0d ch=%0d drv=%0d rule=%0d",
               $realtime, what, want.granted, want.channel, want.drive_level,
               want.rule_used, got.granted, got.channel, got.drive_level,
               got.rule_used);
    end
  endtask

  always @(posedge clk) begin : watch
    vcsa_pkg::res_t want;
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        ch_sound[i] = vcsa_pkg::EMPTY_SOUND;
        ch_vol[i]   = 8'd0;
        ch_prio[i]  = 4'd0;
        ch_age[i]   = 32'sd0;
      end
      last_tick = 32'd0;
      volume    = vcsa_pkg::MASTER_VOL_RESET;
      min_prio  = vcsa_pkg::SAME_SOUND_MIN_PRIO_RESET;
      grant_q.delete();
      err_n = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          vcsa_pkg::CFG_MASTER_VOL:          volume = cfg_data;
          vcsa_pkg::CFG_SAME_SOUND_MIN_PRIO: min_prio = cfg_data;
          default: ;
        endcase
      end
      if (res_valid && res_ready) begin
        if (grant_q.size() == 0) begin
          flag_beat("result beat with none pending", '0, res);
        end else begin
          want = grant_q.pop_front();
          if (res.granted !== want.granted || res.channel !== want.channel ||
              res.drive_level !== want.drive_level ||
              res.rule_used !== want.rule_used) begin
            flag_beat("result mismatch", want, res);
          end
        end
      end
      if (req_valid && req_ready) begin
        allocate_channel(req, want);
        grant_q.push_back(want);
      end
    end
    errors  <= err_n;
    waiting <= grant_q.size();
  end

endmodule

@@ dv/voice_channel_stealing_allocator_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voice_channel_stealing_allocator_test
// Drives play requests and register writes into the allocator, with random
// gaps on the request side and random stalls on the result side. Checking is
// done by the checker module beside the block; this top gives the verdict.
// ----------------------------------------------------------------------------
module voice_channel_stealing_allocator_test;

  localparam int unsigned NUM_CHANNELS    = 8;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES    = NUM_CHANNELS + 4;
  localparam int unsigned PHASE_ITEMS     = 205;
  localparam int unsigned MUTE_ITEMS      = 20;

  // indexes past the last register; writes there must be ignored
  localparam logic [vcsa_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [vcsa_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           req_valid = 1'b0;
  vcsa_pkg::req_t                 req       = '0;
  logic                           res_ready = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic [vcsa_pkg::CFG_IDX_W-1:0] cfg_index = vcsa_pkg::CFG_MASTER_VOL;
  logic [3:0]                     cfg_data  = 4'd0;
  logic                           req_ready;
  logic                           res_valid;
  vcsa_pkg::res_t                 res;
  logic                           cfg_ready;
  int                             errors;
  int                             waiting;

  // idle odds in percent, per side; changed only between phases
  int unsigned send_idle  = 0;
  int unsigned recv_stall = 0;
  bit          hold_off_go = 1'b0;
  logic [31:0] tick_now   = 32'd0;

  // small pool of ids so same-sound reuse actually happens
  logic [15:0] sound_pool [6] = '{vcsa_pkg::EMPTY_SOUND, 16'h0001, 16'h00FF,
                                  16'h1234, 16'hFFFE, 16'h8000};

  always #5 clk = ~clk;

  voice_channel_stealing_allocator #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  voice_channel_stealing_allocator_check #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) grant_check (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .waiting   (waiting)
  );

  // Result side. A hold-off request freezes ready for a long stretch so the
  // result register fills, the block parks in its resolve step and the
  // request side backs up behind it.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_go) begin
        hold_off_go = 1'b0;
        res_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      res_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Offer one request beat and hold it until taken. Valid only drops when a
  // gap is inserted, so back-to-back beats keep valid high across the edge.
  task automatic offer_req(input vcsa_pkg::req_t r);
    if ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic play(input logic [15:0] sid, input logic [7:0] amp,
                      input logic [14:0] pers, input logic [3:0] prio,
                      input logic loaded, input logic [31:0] tick);
    vcsa_pkg::req_t r;
    r = '{sound_id: sid, amplitude: amp, persistence: pers, priority_req: prio,
          sound_loaded: loaded, now_tick: tick};
    tick_now = tick;
    offer_req(r);
  endtask

  // Stop offering and wait until every predicted grant has come back, so the
  // block is idle and registers may be written.
  task automatic close_burst();
    req_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  // Both registers plus one write to a spare index, as one burst of beats.
  task automatic set_config(input logic [3:0] vol, input logic [3:0] min_prio);
    cfg_valid <= 1'b1;
    cfg_index <= vcsa_pkg::CFG_MASTER_VOL;
    cfg_data  <= vol;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= vcsa_pkg::CFG_SAME_SOUND_MIN_PRIO;
    cfg_data  <= min_prio;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= $urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO;
    cfg_data  <= 4'($urandom);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Random request, biased toward loud, high-priority beats on a few ids so
  // the table fills and the later passes (lower priority, oldest) get reached.
  function automatic vcsa_pkg::req_t next_random_req();
    vcsa_pkg::req_t r;
    int unsigned    roll;
    r.sound_id = ($urandom_range(99) < 70) ? sound_pool[$urandom_range(5)] : 16'($urandom);

    roll = $urandom_range(99);
    if (roll < 5)       r.amplitude = 8'd0;
    else if (roll < 45) r.amplitude = 8'd255;
    else if (roll < 70) r.amplitude = 8'($urandom_range(254, 200));
    else                r.amplitude = 8'($urandom_range(255, 1));

    roll = $urandom_range(99);
    if (roll < 60)      r.persistence = 15'($urandom_range(200));
    else if (roll < 90) r.persistence = 15'($urandom);
    else                r.persistence = 15'h7FFF;

    r.priority_req = ($urandom_range(99) < 40) ? 4'd15 : 4'($urandom);
    r.sound_loaded = ($urandom_range(99) < 85);

    // mostly small steps; sometimes a repeat tick, a jump anywhere, or a
    // half-range jump that drives ages into saturation
    roll = $urandom_range(99);
    if (roll < 3)        tick_now = tick_now;
    else if (roll < 8)   tick_now = $urandom;
    else if (roll < 10)  tick_now = tick_now + 32'h8000_0000 + $urandom_range(1000);
    else                 tick_now = tick_now + $urandom_range(400);
    r.now_tick = tick_now;
    return r;
  endfunction

  task automatic run_phase(input int unsigned n, input int unsigned s_idle,
                           input int unsigned r_stall, input logic [3:0] vol,
                           input logic [3:0] min_prio, input bit hold);
    close_burst();
    set_config(vol, min_prio);
    send_idle  = s_idle;
    recv_stall = r_stall;
    if (hold) hold_off_go = 1'b1;
    repeat (n) offer_req(next_random_req());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // ---- directed part, registers at reset values ----
    play(16'h1234, 8'd0, 15'd5, 4'd3, 1'b1, 32'd10);           // zero amplitude, ignored
    play(vcsa_pkg::EMPTY_SOUND, 8'd1, 15'd0, 4'd15, 1'b1, 32'd20); // empty id hits empty channel
    play(16'h0000, 8'd255, 15'h7FFF, 4'd0, 1'b1, 32'd0);       // tick goes backwards: wrap
    play(16'hFFFE, 8'd128, 15'd100, 4'd7, 1'b0, 32'd40);       // sound not loaded
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      play(16'h0100 + 16'(i), 8'd255, 15'h7FFF, 4'd15, 1'b1, 32'd50 + 32'(i));
    end
    play(16'h0200, 8'd255, 15'd10, 4'd15, 1'b1, 32'd60);       // every pass fails
    play(16'h0100, 8'd255, 15'd0, 4'd15, 1'b1, 32'd70);        // same sound, equal volume
    play(16'h0300, 8'd255, 15'd0, 4'd15, 1'b1, 32'hFFFF_FFF0); // oldest channel
    play(16'h0301, 8'd255, 15'd0, 4'd15, 1'b1, 32'h7FFF_FFF0); // saturated ages, tie
    play(16'h0400, 8'd255, 15'h7FFF, 4'd2, 1'b1, 32'h7FFF_FFF8);
    play(16'h0401, 8'd255, 15'd100, 4'd9, 1'b1, 32'h7FFF_FFFA); // lower priority

    close_burst();
    set_config(4'd15, 4'd15);                                  // drive saturates, no reuse
    play(16'h0401, 8'd255, 15'd3, 4'd15, 1'b1, 32'h7FFF_FFFC);
    close_burst();
    set_config(4'd0, 4'd0);                                    // master mute
    play(16'h0500, 8'd200, 15'd1, 4'd1, 1'b1, 32'h8000_0000);
    close_burst();
    set_config(4'd1, 4'd0);                                    // lowest threshold
    play(16'h0401, 8'd255, 15'd0, 4'd1, 1'b1, 32'h8000_0010);
    play(16'h5555, 8'h55, 15'h5555, 4'h5, 1'b1, 32'h5555_5555);
    play(16'hAAAA, 8'hAA, 15'h2AAA, 4'hA, 1'b1, 32'hAAAA_AAAA);

    // ---- random part, one idle profile per phase ----
    run_phase(PHASE_ITEMS, 0, 0, 4'd8, 4'd1, 1'b1);            // long receiver hold-off
    run_phase(PHASE_ITEMS, 59, 0, 4'd15, 4'd0, 1'b0);
    run_phase(PHASE_ITEMS, 0, 59, 4'd1, 4'd15, 1'b0);
    run_phase(PHASE_ITEMS, 19, 19, 4'($urandom_range(15, 1)), 4'($urandom), 1'b0);
    run_phase(PHASE_ITEMS, 0, 0, 4'($urandom_range(15, 1)), 4'($urandom), 1'b0);
    run_phase(PHASE_ITEMS, 59, 0, 4'($urandom_range(15, 1)), 4'($urandom), 1'b0);
    run_phase(PHASE_ITEMS, 0, 59, 4'd15, 4'($urandom), 1'b0);
    run_phase(PHASE_ITEMS, 19, 19, 4'd4, 4'd2, 1'b0);
    run_phase(MUTE_ITEMS, 19, 19, 4'd0, 4'($urandom), 1'b0);   // all beats muted

    close_burst();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && waiting == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
